// ===== design/wmt_pkg.sv =====
// Shared types and constants for the word matrix transpose.
package wmt_pkg;

   localparam int WORD_W     = 32;
   localparam int POS_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 2'd1;

   localparam logic [CSR_DATA_W-1:0] DIM_RESET = 4'd8;

   typedef struct packed {
      logic [WORD_W-1:0] data_word;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_word;
      logic [POS_W-1:0]  out_row;
      logic [POS_W-1:0]  out_col;
      logic              block_last;
   } rsp_payload_type;

   // one loaded block handed from the load side to the emit side
   typedef struct packed {
      logic             bank;
      logic [POS_W-1:0] rows_m1;
      logic [POS_W-1:0] cols_m1;
   } cmd_type;

endpackage

// ===== design/wmt_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
interface wmt_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/wmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// ===== design/wmt_front.sv =====
// Load side: register file, load position tracking and buffer writes.
module wmt_front import wmt_pkg::*; #(
   parameter int MAX_DIM = 8,
   parameter int ADDR_W  = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   input  logic                  cmd_full,
   output logic                  cmd_push,
   output cmd_type               cmd_data,
   output logic                  wr_en,
   output logic [ADDR_W-1:0]     wr_addr,
   output logic [WORD_W-1:0]     wr_data
);
   localparam int BANK_WORDS = MAX_DIM * MAX_DIM;
   localparam logic [CSR_DATA_W-1:0] MAX_RAW = CSR_DATA_W'(MAX_DIM);

   logic [CSR_DATA_W-1:0] num_rows_ff, num_rows_in;
   logic [CSR_DATA_W-1:0] num_cols_ff, num_cols_in;
   logic [POS_W-1:0]      row_ff, row_in;
   logic [POS_W-1:0]      col_ff, col_in;
   logic                  bank_ff, bank_in;
   logic [POS_W-1:0]      rows_m1, cols_m1;
   logic                  accept, row_end, col_end;

   function automatic logic [POS_W-1:0] dim_m1(input logic [CSR_DATA_W-1:0] raw);
      logic [CSR_DATA_W-1:0] d;
      if (raw == '0) begin
         d = CSR_DATA_W'(1);
      end else if (raw > MAX_RAW) begin
         d = MAX_RAW;
      end else begin
         d = raw;
      end
      dim_m1 = POS_W'(d - CSR_DATA_W'(1));
   endfunction

   assign rows_m1   = dim_m1(num_rows_ff);
   assign cols_m1   = dim_m1(num_cols_ff);
   assign req_ready = !cmd_full;
   assign accept    = req_valid && req_ready;
   assign col_end   = (col_ff == cols_m1);
   assign row_end   = (row_ff == rows_m1);

   assign wr_en   = accept;
   assign wr_data = req_payload.data_word;
   assign wr_addr = ADDR_W'(bank_ff) * ADDR_W'(BANK_WORDS)
                  + ADDR_W'(row_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(col_ff);

   assign cmd_push         = accept && row_end && col_end;
   assign cmd_data.bank    = bank_ff;
   assign cmd_data.rows_m1 = rows_m1;
   assign cmd_data.cols_m1 = cols_m1;

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      bank_in     = bank_ff;
      if (csr_we) begin
         unique case (csr_idx)
            CSR_NUM_ROWS: begin
               num_rows_in = csr_wdata;
               row_in      = '0;
               col_in      = '0;
            end
            CSR_NUM_COLS: begin
               num_cols_in = csr_wdata;
               row_in      = '0;
               col_in      = '0;
            end
            default: ;
         endcase
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               row_in  = '0;
               bank_in = !bank_ff;
            end else begin
               row_in = row_ff + POS_W'(1);
            end
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= DIM_RESET;
         num_cols_ff <= DIM_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         bank_ff     <= 1'b0;
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         bank_ff     <= bank_in;
      end
   end
endmodule

// ===== design/wmt_cmd_fifo.sv =====
// Two-entry queue of loaded blocks waiting to be emitted.
module wmt_cmd_fifo import wmt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);
   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

// ===== design/wmt_back.sv =====
// Emit side: walks a loaded block column by column and drives the result beats.
module wmt_back import wmt_pkg::*; #(
   parameter int MAX_DIM = 8,
   parameter int ADDR_W  = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd_head,
   output logic              cmd_pop,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [WORD_W-1:0] rd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_payload
);
   localparam int BANK_WORDS = MAX_DIM * MAX_DIM;

   // walk position: in_row is the input row (output column)
   logic [POS_W-1:0] in_row_ff, in_row_in;
   logic [POS_W-1:0] in_col_ff, in_col_in;
   // read stage: RAM data lands alongside these
   logic             p1_valid_ff, p1_valid_in;
   logic [POS_W-1:0] p1_row_ff, p1_col_ff;
   logic             p1_last_ff;
   // output register
   logic             out_valid_ff, out_valid_in;
   rsp_payload_type  out_payload_ff;

   logic out_free, p1_free, issue, row_end, col_end;

   assign out_free = !out_valid_ff || rsp_ready;
   assign p1_free  = !p1_valid_ff || out_free;
   assign issue    = cmd_valid && p1_free;
   assign row_end  = (in_row_ff == cmd_head.rows_m1);
   assign col_end  = (in_col_ff == cmd_head.cols_m1);
   assign cmd_pop  = issue && row_end && col_end;

   assign rd_en   = issue;
   assign rd_addr = ADDR_W'(cmd_head.bank) * ADDR_W'(BANK_WORDS)
                  + ADDR_W'(in_row_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col_ff);

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

   always_comb begin
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      p1_valid_in  = p1_free ? issue : p1_valid_ff;
      out_valid_in = out_free ? p1_valid_ff : out_valid_ff;
      if (issue) begin
         if (row_end) begin
            in_row_in = '0;
            in_col_in = col_end ? '0 : in_col_ff + POS_W'(1);
         end else begin
            in_row_in = in_row_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p1_free) begin
         p1_row_ff  <= in_col_ff;
         p1_col_ff  <= in_row_ff;
         p1_last_ff <= row_end && col_end;
      end
      if (out_free) begin
         out_payload_ff.out_word   <= rd_data;
         out_payload_ff.out_row    <= p1_row_ff;
         out_payload_ff.out_col    <= p1_col_ff;
         out_payload_ff.block_last <= p1_last_ff;
      end
      if (reset) begin
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

// ===== design/word_matrix_transpose.sv =====
// Top level of the word matrix transpose (corner turn).
// Usage:
//  - csr_*: write num_rows (index 0) and num_cols (index 1), 4 bits each, while
//    idle. 0 reads as 1, values above MAX_DIM as MAX_DIM. Either write restarts
//    loading at row 0, column 0; words of a partial block are dropped.
//  - req_chan: one 32-bit word per beat, input matrix in row-major order.
//  - rsp_chan: after the last word of a block, rows*cols beats in transposed
//    order; out_row is the input column, out_col the input row, block_last
//    marks the final beat.
// Timing:
//  - Loading takes one beat per cycle while req_chan.ready is high. After the
//    completing word is taken, the block passes the block queue, the RAM read
//    and the output register before its first result beat shows; then beats
//    flow one per cycle while the receiver is ready, via the single read port.
//  - The buffer holds two banks; the load side fills one while the emit side
//    drains the other. req_chan.ready drops only while both banks hold blocks.
//  - A stalled receiver holds the output register and the read stage; the
//    load side keeps taking words until both banks are full.
// Reset: synchronous; clears positions, the block queue and the output
//  register, sets both dimensions to 8. The buffer itself is not cleared.
module word_matrix_transpose import wmt_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   wmt_stream_if.sink            req_chan,
   wmt_stream_if.source          rsp_chan
);
   // two banks of MAX_DIM x MAX_DIM words
   localparam int RAM_DEPTH = 2 * MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);

   logic              cmd_full, cmd_push, cmd_pop, cmd_not_empty;
   cmd_type           cmd_in, cmd_head;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;
   logic              req_ready;
   req_payload_type   req_payload;
   rsp_payload_type   rsp_payload;
   logic              rsp_valid;

   assign req_payload      = req_chan.payload;
   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

   wmt_front #(.MAX_DIM(MAX_DIM), .ADDR_W(ADDR_W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_idx     (csr_idx),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_chan.valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   // a block stays queued until its last read is issued, which frees its bank
   wmt_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .full      (cmd_full),
      .not_empty (cmd_not_empty),
      .head      (cmd_head)
   );

   wmt_ram #(.WIDTH(WORD_W), .DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wmt_back #(.MAX_DIM(MAX_DIM), .ADDR_W(ADDR_W)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_not_empty),
      .cmd_head    (cmd_head),
      .cmd_pop     (cmd_pop),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_payload)
   );
endmodule

// ===== design/wmt_checker.sv =====
// Port-level checks on the transpose result channel, bound to the top level.
module wmt_checker import wmt_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);
   logic rsp_beat;
   assign rsp_beat = rsp_valid && rsp_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result payload changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat straight after reset");

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_payload.block_last |=>
         !rsp_valid || (rsp_payload.out_row == '0 && rsp_payload.out_col == '0))
      else $error("block does not start at the origin");

   a_col_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && !rsp_payload.block_last |=>
         !rsp_valid || rsp_payload.out_col == '0
         || rsp_payload.out_col == $past(rsp_payload.out_col) + POS_W'(1))
      else $error("output column skipped");
endmodule

bind word_matrix_transpose wmt_checker u_wmt_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
